/* sv/stb_pkg.sv */
package stb_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = KEY_BITS + VALUE_BITS;

    localparam int KEY_FIELD_W = 32;
    localparam int VAL_FIELD_W = 32;
    localparam int POS_W       = 9;

    typedef enum logic [1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RSVD      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]             action;
        logic [KEY_FIELD_W-1:0] search_key;
        logic [VAL_FIELD_W-1:0] entry_value;
        logic [POS_W-1:0]       insert_index;
    } in_item_t;

    typedef struct packed {
        logic                   hit;
        logic [VAL_FIELD_W-1:0] found_value;
        logic [POS_W-1:0]       position;
        logic [1:0]             status;
        logic [POS_W-1:0]       entry_count;
    } out_item_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ENT_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

/* sv/stb_ram.sv */
module stb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/stb_ctrl.sv */
module stb_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  stb_pkg::in_item_t          s_item,
    output logic                       res_valid,
    input  logic                       res_ready,
    output stb_pkg::out_item_t         res_item,
    output stb_pkg::ram_req_t          ram_req,
    input  logic [stb_pkg::ENT_W-1:0]  ram_rdata
);

    localparam int CW = stb_pkg::CNT_W;
    localparam int IW = stb_pkg::IDX_W;
    localparam int KW = stb_pkg::KEY_BITS;
    localparam int VW = stb_pkg::VALUE_BITS;
    localparam int PW = stb_pkg::POS_W;
    localparam int FW = stb_pkg::VAL_FIELD_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      act_reg, act_next;
    logic [KW-1:0]   key_reg, key_next;
    logic [VW-1:0]   val_reg, val_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [IW-1:0]   mid_reg, mid_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic            hit_reg, hit_next;
    logic [VW-1:0]   found_reg, found_next;
    logic [1:0]      status_reg, status_next;
    logic [CW-1:0]   sh_ptr_reg, sh_ptr_next;
    logic            rd_act_reg, rd_act_next;
    logic            wr_pend_reg, wr_pend_next;
    logic [IW-1:0]   wr_addr_reg, wr_addr_next;

    logic [CW-1:0]   mid_w;
    logic [CW-1:0]   mid_ext;
    logic [CW-1:0]   idx_w;
    logic [CW-1:0]   clamp_w;
    logic [KW-1:0]   rd_key;
    logic [VW-1:0]   rd_val;

    assign mid_w   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_ext = CW'(mid_reg);
    assign idx_w   = CW'(s_item.insert_index);
    assign clamp_w = (idx_w > cnt_reg) ? cnt_reg : idx_w;
    assign rd_key  = ram_rdata[stb_pkg::ENT_W-1 -: KW];
    assign rd_val  = ram_rdata[VW-1:0];

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res_item             = '0;
        res_item.hit         = hit_reg;
        res_item.found_value = FW'(found_reg);
        res_item.position    = PW'(pos_reg);
        res_item.status      = status_reg;
        res_item.entry_count = PW'(cnt_reg);
    end

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        sh_ptr_next  = sh_ptr_reg;
        rd_act_next  = rd_act_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;

        ram_req       = '0;
        ram_req.raddr = mid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next    = s_item.action;
                    key_next    = s_item.search_key[KW-1:0];
                    val_next    = s_item.entry_value[VW-1:0];
                    hit_next    = 1'b0;
                    found_next  = '0;
                    status_next = stb_pkg::STAT_OK;
                    pos_next    = '0;
                    lo_next     = '0;
                    hi_next     = cnt_reg;
                    case (s_item.action)
                        stb_pkg::ACT_FIND, stb_pkg::ACT_REMOVE: begin
                            state_next = ST_READ;
                        end
                        stb_pkg::ACT_INSERT: begin
                            pos_next = clamp_w;
                            if (cnt_reg >= CW'(stb_pkg::CAPACITY)) begin
                                status_next = stb_pkg::STAT_FULL;
                                state_next  = ST_DONE;
                            end else begin
                                sh_ptr_next  = cnt_reg - CW'(1);
                                rd_act_next  = (cnt_reg > clamp_w);
                                wr_pend_next = 1'b0;
                                state_next   = ST_SHIFT;
                            end
                        end
                        default: begin
                            cnt_next   = '0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (lo_reg < hi_reg) begin
                    mid_next      = mid_w[IW-1:0];
                    ram_req.raddr = mid_w[IW-1:0];
                    state_next    = ST_CMP;
                end else begin
                    pos_next    = lo_reg;
                    status_next = stb_pkg::STAT_NOT_FOUND;
                    state_next  = ST_DONE;
                end
            end
            ST_CMP: begin
                if (rd_key > key_reg) begin
                    hi_next    = mid_ext;
                    state_next = ST_READ;
                end else if (rd_key == key_reg) begin
                    hit_next   = 1'b1;
                    found_next = rd_val;
                    pos_next   = mid_ext;
                    if (act_reg == stb_pkg::ACT_REMOVE) begin
                        sh_ptr_next  = mid_ext + CW'(1);
                        rd_act_next  = ((mid_ext + CW'(1)) < cnt_reg);
                        wr_pend_next = 1'b0;
                        state_next   = ST_SHIFT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    lo_next    = mid_ext + CW'(1);
                    state_next = ST_READ;
                end
            end
            ST_SHIFT: begin
                ram_req.raddr = sh_ptr_reg[IW-1:0];
                if (wr_pend_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = wr_addr_reg;
                    ram_req.wdata = ram_rdata;
                end
                if (rd_act_reg) begin
                    wr_pend_next = 1'b1;
                    if (act_reg == stb_pkg::ACT_INSERT) begin
                        wr_addr_next = sh_ptr_reg[IW-1:0] + IW'(1);
                        sh_ptr_next  = sh_ptr_reg - CW'(1);
                        rd_act_next  = (sh_ptr_reg > pos_reg);
                    end else begin
                        wr_addr_next = sh_ptr_reg[IW-1:0] - IW'(1);
                        sh_ptr_next  = sh_ptr_reg + CW'(1);
                        rd_act_next  = ((sh_ptr_reg + CW'(1)) < cnt_reg);
                    end
                end else begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (act_reg == stb_pkg::ACT_INSERT) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg[IW-1:0];
                    ram_req.wdata = {key_reg, val_reg};
                    cnt_next      = cnt_reg + CW'(1);
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_act_reg  <= 1'b0;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_act_reg  <= rd_act_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        pos_reg     <= pos_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        sh_ptr_reg  <= sh_ptr_next;
        wr_addr_reg <= wr_addr_next;
    end

endmodule

/* sv/sorted_table_binary_search.sv */
// Sorted key/value table with binary search, insert, remove and clear over a
// single RAM of CAPACITY entries with one write and one registered read per
// cycle. The block takes one request at a time and drops s_ready until its
// result is handed to the output register. Find runs one probe after another,
// each a read, then a compare. Remove, after its search, moves each entry above
// the hit down one place; insert moves each entry at or above its position up
// one place, then writes the new entry, so a full-length shift moves CAPACITY
// - 1 entries. The RAM port, one read per cycle, paces the probes and shifts.
// Clear and an insert into a full table go straight to the result. No
// clearing pass runs after reset: only entries below the count are ever used.
module sorted_table_binary_search (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stb_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output stb_pkg::out_item_t m_item
);

    logic                      res_valid;
    logic                      res_ready;
    stb_pkg::out_item_t        res_item;
    stb_pkg::ram_req_t         ram_req;
    logic [stb_pkg::ENT_W-1:0] ram_rdata;

    logic                      out_valid_reg, out_valid_next;
    stb_pkg::out_item_t        out_item_reg, out_item_next;

    stb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    stb_ram #(
        .WIDTH (stb_pkg::ENT_W),
        .DEPTH (stb_pkg::CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_item_next  = res_item;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg <= out_item_next;
    end

endmodule

/* sv/stb_check.sv */
module stb_check (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input stb_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input stb_pkg::out_item_t m_item
);

    localparam int PW = stb_pkg::POS_W;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready did not drop after an item was taken");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.entry_count <= PW'(stb_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.hit |-> m_item.status == stb_pkg::STAT_OK)
        else $error("hit reported with an error status");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.hit |-> m_item.found_value == '0)
        else $error("value reported without a hit");

endmodule

bind sorted_table_binary_search stb_check u_check (.*);
